// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/bsba_pkg.sv =====
// ----------------------------------------------------------------------------
// bsba_pkg
// Types and constants of the banked SRAM bump allocator.
// ----------------------------------------------------------------------------
package bsba_pkg;

  localparam int unsigned SizeW    = 21;
  localparam int unsigned BankW    = 3;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RemCntW  = 5;

  localparam logic [SizeW-1:0] BankBytesReset = 21'h100000;

  typedef enum logic [StatusW-1:0] {
    STAT_OK         = 3'd0,
    STAT_ZERO_SIZE  = 3'd1,
    STAT_ZERO_ALIGN = 3'd2,
    STAT_BAD_BANK   = 3'd3,
    STAT_EXHAUSTED  = 3'd4
  } alloc_status_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_CHECK,
    CS_LOAD,
    CS_WAIT,
    CS_EVAL,
    CS_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic rem_start;
    logic eval;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic early_err;
    logic rem_done;
    logic last_bank;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/bsba_if.sv =====
// ----------------------------------------------------------------------------
// bsba_if
// Request and response channel interfaces (valid/ready plus payload).
// ----------------------------------------------------------------------------
interface bsba_req_if;
  logic                       valid;
  logic                       ready;
  logic [bsba_pkg::SizeW-1:0] size_bytes;
  logic [bsba_pkg::SizeW-1:0] alignment;
  logic                       use_preferred;
  logic [bsba_pkg::BankW-1:0] pref_bank;

  modport source (output valid, size_bytes, alignment, use_preferred, pref_bank,
                  input ready);
  modport sink   (input valid, size_bytes, alignment, use_preferred, pref_bank,
                  output ready);
endinterface

interface bsba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bsba_pkg::StatusW-1:0] status;
  logic [bsba_pkg::BankW-1:0]   bank;
  logic [bsba_pkg::SizeW-1:0]   offset;

  modport source (output valid, status, bank, offset, input ready);
  modport sink   (input valid, status, bank, offset, output ready);
endinterface

// ===== rtl/bsba_rem.sv =====
// ----------------------------------------------------------------------------
// bsba_rem
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bsba_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bsba_pkg::SizeW-1:0] dividend,
  input  logic [bsba_pkg::SizeW-1:0] divisor,
  output logic                       busy,
  output logic [bsba_pkg::SizeW-1:0] remainder
);
  import bsba_pkg::*;

  logic               busy_r;
  logic [RemCntW-1:0] cnt_r;
  logic [SizeW-1:0]   rem_r, rem_nxt;
  logic [SizeW-1:0]   dvd_r;
  logic [SizeW-1:0]   div_r;
  logic [SizeW:0]     trial;

  always_comb begin
    trial = {rem_r, dvd_r[SizeW-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = SizeW'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[SizeW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= RemCntW'(SizeW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - RemCntW'(1);
      if (cnt_r == RemCntW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[SizeW-2:0], 1'b0};
    end
  end

  assign busy      = busy_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/bsba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsba_ctrl
// Sequencer: accept, check, per-bank remainder and fit test, commit.
// ----------------------------------------------------------------------------
module bsba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bsba_pkg::dp_sts_t sts,
  output bsba_pkg::dp_cmd_t cmd
);
  import bsba_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_CHECK;
      end
      CS_CHECK: begin
        state_nxt = sts.early_err ? CS_COMMIT : CS_LOAD;
      end
      CS_LOAD: begin
        state_nxt = CS_WAIT;
      end
      CS_WAIT: begin
        if (sts.rem_done) state_nxt = CS_EVAL;
      end
      CS_EVAL: begin
        state_nxt = sts.last_bank ? CS_COMMIT : CS_LOAD;
      end
      CS_COMMIT: begin
        if (sts.out_free) state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      CS_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      CS_LOAD: begin
        cmd.rem_start = 1'b1;
      end
      CS_EVAL: begin
        cmd.eval = 1'b1;
      end
      CS_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/bsba_dp.sv =====
// ----------------------------------------------------------------------------
// bsba_dp
// Datapath: request registers, bank cursors, fit test, best-bank tracking,
// result register.
// ----------------------------------------------------------------------------
module bsba_dp #(
  parameter int unsigned BANK_COUNT = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsba_pkg::dp_cmd_t            cmd,
  output bsba_pkg::dp_sts_t            sts,
  input  logic [bsba_pkg::SizeW-1:0]   bank_bytes,
  input  logic [bsba_pkg::SizeW-1:0]   in_size_bytes,
  input  logic [bsba_pkg::SizeW-1:0]   in_alignment,
  input  logic                         in_use_preferred,
  input  logic [bsba_pkg::BankW-1:0]   in_pref_bank,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bsba_pkg::StatusW-1:0] out_status,
  output logic [bsba_pkg::BankW-1:0]   out_bank,
  output logic [bsba_pkg::SizeW-1:0]   out_offset
);
  import bsba_pkg::*;

  localparam int unsigned IdxW      = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam logic [BankW:0] BankLimit = (BankW+1)'(BANK_COUNT);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(BANK_COUNT - 1);

  logic [SizeW-1:0] size_r, align_r;
  logic             use_pref_r, bad_bank_r;
  logic [IdxW-1:0]  idx_r, best_idx_r;
  logic             found_r;
  logic [SizeW-1:0] best_cur_r, best_start_r;
  logic [SizeW-1:0] cursor_r [BANK_COUNT];

  logic                out_valid_r;
  logic [StatusW-1:0]  out_status_r;
  logic [BankW-1:0]    out_bank_r;
  logic [SizeW-1:0]    out_offset_r;

  logic [SizeW-1:0]   cur, rem, adj;
  logic               rem_busy;
  logic [SizeW:0]     start_sum;
  logic [SizeW+1:0]   end_sum;
  logic               fit, better;
  alloc_status_t      stat_nxt;

  bsba_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.rem_start),
    .dividend  (cursor_r[idx_r]),
    .divisor   (align_r),
    .busy      (rem_busy),
    .remainder (rem)
  );

  always_comb begin
    cur       = cursor_r[idx_r];
    adj       = (rem == '0) ? '0 : (align_r - rem);
    start_sum = {1'b0, cur} + {1'b0, adj};
    end_sum   = {1'b0, start_sum} + {2'b00, size_r};
    fit       = end_sum <= {2'b00, bank_bytes};
    better    = !found_r || (cur < best_cur_r);
  end

  always_comb begin
    if (size_r == '0) begin
      stat_nxt = STAT_ZERO_SIZE;
    end else if (align_r == '0) begin
      stat_nxt = STAT_ZERO_ALIGN;
    end else if (bad_bank_r) begin
      stat_nxt = STAT_BAD_BANK;
    end else if (found_r) begin
      stat_nxt = STAT_OK;
    end else begin
      stat_nxt = STAT_EXHAUSTED;
    end
  end

  assign sts.early_err = (size_r == '0) || (align_r == '0) || bad_bank_r;
  assign sts.rem_done  = !rem_busy;
  assign sts.last_bank = use_pref_r || (idx_r == LastIdx);
  assign sts.out_free  = !out_valid_r || out_ready;

  // request registers and scan state
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      size_r     <= in_size_bytes;
      align_r    <= in_alignment;
      use_pref_r <= in_use_preferred;
      bad_bank_r <= in_use_preferred && ({1'b0, in_pref_bank} >= BankLimit);
      idx_r      <= in_use_preferred ? in_pref_bank[IdxW-1:0] : '0;
    end else if (cmd.eval) begin
      idx_r <= idx_r + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.accept) begin
      found_r <= 1'b0;
    end else if (cmd.eval && fit && better) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && fit && better) begin
      best_idx_r   <= idx_r;
      best_cur_r   <= cur;
      best_start_r <= start_sum[SizeW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BANK_COUNT; i++) begin
        cursor_r[i] <= '0;
      end
    end else if (cmd.commit && (stat_nxt == STAT_OK)) begin
      cursor_r[best_idx_r] <= best_start_r + size_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= stat_nxt;
      out_bank_r   <= (stat_nxt == STAT_OK) ? BankW'(best_idx_r) : '0;
      out_offset_r <= (stat_nxt == STAT_OK) ? best_start_r : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_bank   = out_bank_r;
  assign out_offset = out_offset_r;

endmodule

// ===== rtl/banked_sram_bump_allocator.sv =====
// ----------------------------------------------------------------------------
// banked_sram_bump_allocator
// Bump allocator over BANK_COUNT SRAM banks with an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : allocation request (size_bytes, alignment, use_preferred,
//             pref_bank), taken when valid and ready are both high.
//   out_rsp : one response per request (status, bank, offset).
//   APB     : register 0 at byte 0 is bank_bytes (21 bits, reset 1048576).
//             Write it only while no request is in flight.
// One request at a time. Each bank tried runs the 21-step remainder unit,
//   whose result rounds the cursor up to the alignment; only the preferred
//   bank is tried when one is given, all BANK_COUNT banks otherwise, and a
//   rejected request skips the scan and goes straight to its response.
// The next request is accepted once the previous response sits in the output
//   register; a stalled response holds there and blocks only the commit of the
//   next one.
// Reset: synchronous, active low; all cursors return to zero, bank_bytes to
//   1048576, no response pending.
// ----------------------------------------------------------------------------
module banked_sram_bump_allocator #(
  parameter int unsigned BANK_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bsba_req_if.sink                      in_req,
  bsba_rsp_if.source                    out_rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsba_pkg::CfgAddrW-1:0] paddr,
  input  logic [bsba_pkg::CfgDataW-1:0] pwdata,
  output logic [bsba_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import bsba_pkg::*;

  logic [SizeW-1:0] bank_bytes_r;
  logic             reg0_sel;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign reg0_sel = (paddr[CfgAddrW-1] == 1'b0);
  assign pready   = 1'b1;
  assign prdata   = reg0_sel ? {(CfgDataW-SizeW)'(0), bank_bytes_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_bytes_r <= BankBytesReset;
    end else if (psel && penable && pwrite && reg0_sel) begin
      bank_bytes_r <= pwdata[SizeW-1:0];
    end
  end

  bsba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsba_dp #(
    .BANK_COUNT (BANK_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .bank_bytes        (bank_bytes_r),
    .in_size_bytes     (in_req.size_bytes),
    .in_alignment      (in_req.alignment),
    .in_use_preferred  (in_req.use_preferred),
    .in_pref_bank      (in_req.pref_bank),
    .out_valid         (out_rsp.valid),
    .out_ready         (out_rsp.ready),
    .out_status        (out_rsp.status),
    .out_bank          (out_rsp.bank),
    .out_offset        (out_rsp.offset)
  );

endmodule

// ===== rtl/bsba_checker.sv =====
// ----------------------------------------------------------------------------
// bsba_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsba_checker #(
  parameter int unsigned BANK_COUNT = 4
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bsba_pkg::StatusW-1:0] out_status,
  input logic [bsba_pkg::BankW-1:0]   out_bank,
  input logic [bsba_pkg::SizeW-1:0]   out_offset
);
  import bsba_pkg::*;

  localparam logic [BankW-1:0] BankMax = BankW'(BANK_COUNT - 1);

  `ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_bank) && $stable(out_offset))
  `ASSERT_SAME(a_fail_zero, clk, rst_n, out_valid && (out_status != STAT_OK), (out_bank == '0) && (out_offset == '0))
  `ASSERT_SAME(a_ok_bank, clk, rst_n, out_valid && (out_status == STAT_OK), out_bank <= BankMax)
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind banked_sram_bump_allocator bsba_checker #(
  .BANK_COUNT (BANK_COUNT)
) u_bsba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_status (out_rsp.status),
  .out_bank   (out_rsp.bank),
  .out_offset (out_rsp.offset)
);
